### hw/rtl/pbmrs_pkg.sv
// ----------------------------------------------------------------------------
// pbmrs_pkg
// Shared types and constants for per-block modulation and rate selection.
// ----------------------------------------------------------------------------
package pbmrs_pkg;

  localparam int unsigned NUM_BLOCKS = 4;
  localparam int unsigned NUM_THR    = 7;
  localparam int unsigned SNR_W      = 16;
  localparam int unsigned IDX_W      = $clog2(NUM_THR + 1);
  localparam int unsigned BITS_W     = 3;
  localparam int unsigned SUM_W      = $clog2(6 * NUM_BLOCKS + 1);
  localparam int unsigned CMP_W      = SUM_W + 2;

  typedef enum logic [1:0] {
    MOD_BPSK  = 2'd0,
    MOD_QPSK  = 2'd1,
    MOD_QAM16 = 2'd2,
    MOD_QAM64 = 2'd3
  } mod_e;

  typedef enum logic [1:0] {
    RATE_12 = 2'd0,
    RATE_23 = 2'd1,
    RATE_34 = 2'd2
  } rate_e;

  // Threshold register indexes, top step of the ladder first
  typedef enum logic [IDX_W-1:0] {
    REG_QAM64_R34 = IDX_W'(0),
    REG_QAM64_R23 = IDX_W'(1),
    REG_QAM16_R34 = IDX_W'(2),
    REG_QAM16_R12 = IDX_W'(3),
    REG_QPSK_R34  = IDX_W'(4),
    REG_QPSK_R12  = IDX_W'(5),
    REG_BPSK_R34  = IDX_W'(6)
  } reg_idx_e;

  typedef logic [NUM_THR-1:0][SNR_W-1:0] thr_vec_t;

  localparam thr_vec_t THR_RESET = {
    16'd1024, 16'd1792, 16'd2560, 16'd3584, 16'd4608, 16'd5632, 16'd6400
  };

  localparam mod_e [NUM_THR-1:0] STEP_MOD = {
    MOD_BPSK, MOD_QPSK, MOD_QPSK, MOD_QAM16, MOD_QAM16, MOD_QAM64, MOD_QAM64
  };

  localparam rate_e [NUM_THR-1:0] STEP_RATE = {
    RATE_34, RATE_12, RATE_34, RATE_12, RATE_34, RATE_23, RATE_34
  };

  typedef struct packed {
    mod_e  mod;
    rate_e rate;
    mod_e  low;
  } lane_res_t;

  typedef lane_res_t [NUM_BLOCKS-1:0] lane_vec_t;

  typedef struct packed {
    mod_e [NUM_BLOCKS-1:0] mods;
    rate_e                 code;
  } dec_t;

  function automatic logic [BITS_W-1:0] mod_bits(input mod_e m);
    logic [BITS_W-1:0] b;
    unique case (m)
      MOD_BPSK:  b = BITS_W'(1);
      MOD_QPSK:  b = BITS_W'(2);
      MOD_QAM16: b = BITS_W'(4);
      MOD_QAM64: b = BITS_W'(6);
      default:   b = BITS_W'(1);
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/pbmrs_in_if.sv
// ----------------------------------------------------------------------------
// pbmrs_in_if
// Input channel: one word carries the SNR of every resource block.
// ----------------------------------------------------------------------------
interface pbmrs_in_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] snr_rb0;
  logic signed [15:0] snr_rb1;
  logic signed [15:0] snr_rb2;
  logic signed [15:0] snr_rb3;

  modport source (output valid, output snr_rb0, output snr_rb1, output snr_rb2,
                  output snr_rb3, input ready);
  modport sink   (input valid, input snr_rb0, input snr_rb1, input snr_rb2,
                  input snr_rb3, output ready);
endinterface

### hw/rtl/pbmrs_out_if.sv
// ----------------------------------------------------------------------------
// pbmrs_out_if
// Output channel: per-block modulation and the common code rate.
// ----------------------------------------------------------------------------
interface pbmrs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mod_rb0;
  logic [1:0] mod_rb1;
  logic [1:0] mod_rb2;
  logic [1:0] mod_rb3;
  logic [1:0] code_rate;

  modport source (output valid, output mod_rb0, output mod_rb1, output mod_rb2,
                  output mod_rb3, output code_rate, input ready);
  modport sink   (input valid, input mod_rb0, input mod_rb1, input mod_rb2,
                  input mod_rb3, input code_rate, output ready);
endinterface

### hw/rtl/pbmrs_lane.sv
// ----------------------------------------------------------------------------
// pbmrs_lane
// Threshold ladder for one resource block, registered result.
// ----------------------------------------------------------------------------
module pbmrs_lane (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [pbmrs_pkg::SNR_W-1:0]      snr_i,
  input  pbmrs_pkg::thr_vec_t                     thr_i,
  output pbmrs_pkg::lane_res_t                    res_o
);

  pbmrs_pkg::lane_res_t res_d, res_q;

  always_comb begin
    res_d.mod  = pbmrs_pkg::MOD_BPSK;
    res_d.rate = pbmrs_pkg::RATE_12;
    // Walk bottom-up so the highest step met wins
    for (int k = pbmrs_pkg::NUM_THR - 1; k >= 0; k--) begin
      if (snr_i >= $signed(thr_i[k])) begin
        res_d.mod  = pbmrs_pkg::STEP_MOD[k];
        res_d.rate = pbmrs_pkg::STEP_RATE[k];
      end
    end
    if (res_d.rate == pbmrs_pkg::RATE_12 && res_d.mod != pbmrs_pkg::MOD_BPSK) begin
      res_d.low = pbmrs_pkg::mod_e'(2'(res_d.mod) - 2'd1);
    end else begin
      res_d.low = res_d.mod;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### hw/rtl/pbmrs_merge.sv
// ----------------------------------------------------------------------------
// pbmrs_merge
// Combines the lane results into one common code rate and final modulations.
// ----------------------------------------------------------------------------
module pbmrs_merge (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  pbmrs_pkg::lane_vec_t lane_i,
  output pbmrs_pkg::dec_t      dec_o
);

  logic all_r12, all_r23, all_r34, all_q64, any_bpsk12, use_low;
  logic [pbmrs_pkg::SUM_W-1:0] sum_half, sum_low;
  logic [pbmrs_pkg::CMP_W-1:0] tp_half, tp_low;
  pbmrs_pkg::dec_t dec_d, dec_q;

  always_comb begin
    all_r12    = 1'b1;
    all_r23    = 1'b1;
    all_r34    = 1'b1;
    all_q64    = 1'b1;
    any_bpsk12 = 1'b0;
    sum_half   = '0;
    sum_low    = '0;
    for (int i = 0; i < pbmrs_pkg::NUM_BLOCKS; i++) begin
      all_r12 &= (lane_i[i].rate == pbmrs_pkg::RATE_12);
      all_r23 &= (lane_i[i].rate == pbmrs_pkg::RATE_23);
      all_r34 &= (lane_i[i].rate == pbmrs_pkg::RATE_34);
      all_q64 &= (lane_i[i].mod == pbmrs_pkg::MOD_QAM64);
      any_bpsk12 |= (lane_i[i].mod == pbmrs_pkg::MOD_BPSK) &&
                    (lane_i[i].rate == pbmrs_pkg::RATE_12);
      sum_half += pbmrs_pkg::SUM_W'(pbmrs_pkg::mod_bits(lane_i[i].mod));
      sum_low  += pbmrs_pkg::SUM_W'(pbmrs_pkg::mod_bits(lane_i[i].low));
    end
    // 2 x throughput at 1/2 against 3 x lowered throughput at 3/4
    tp_half = {1'b0, sum_half, 1'b0};
    tp_low  = {2'b00, sum_low} + {1'b0, sum_low, 1'b0};
  end

  always_comb begin
    use_low = 1'b0;
    priority if (all_r12) begin
      dec_d.code = pbmrs_pkg::RATE_12;
    end else if (all_r23) begin
      dec_d.code = pbmrs_pkg::RATE_23;
    end else if (all_r34) begin
      dec_d.code = pbmrs_pkg::RATE_34;
    end else if (all_q64) begin
      dec_d.code = pbmrs_pkg::RATE_23;
    end else if (any_bpsk12) begin
      dec_d.code = pbmrs_pkg::RATE_12;
    end else if (tp_half > tp_low) begin
      dec_d.code = pbmrs_pkg::RATE_12;
    end else begin
      dec_d.code = pbmrs_pkg::RATE_34;
      use_low    = 1'b1;
    end
    for (int i = 0; i < pbmrs_pkg::NUM_BLOCKS; i++) begin
      dec_d.mods[i] = use_low ? lane_i[i].low : lane_i[i].mod;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign dec_o = dec_q;

endmodule

### hw/rtl/per_block_modulation_and_rate_select.sv
// Path: an accepted word is registered in its lane, then in the merge stage.
// Throughput: one word per cycle while the output takes results; the four
// block ladders run in parallel lanes and a single merge stage produces the common rate.
// Reset: thresholds return to their defaults and both pipeline stages empty.
// The output register lets a new word enter while a result waits to be taken.
// ----------------------------------------------------------------------------
// per_block_modulation_and_rate_select
// Per-block modulation choice from SNR thresholds and common code-rate merge.
// ----------------------------------------------------------------------------
module per_block_modulation_and_rate_select (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pbmrs_in_if.sink                           in_s,
  pbmrs_out_if.source                        out_m,
  input  logic                               cfg_we_i,
  input  logic [pbmrs_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [pbmrs_pkg::SNR_W-1:0]        cfg_wdata_i
);

  pbmrs_pkg::thr_vec_t  thr_q;
  logic signed [pbmrs_pkg::SNR_W-1:0] snr [pbmrs_pkg::NUM_BLOCKS];
  pbmrs_pkg::lane_vec_t lane_res;
  pbmrs_pkg::dec_t      dec;
  logic s1_valid_d, s1_valid_q, out_valid_d, out_valid_q;
  logic out_adv, in_acc;

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= pbmrs_pkg::THR_RESET;
    end else if (cfg_we_i && cfg_idx_i < pbmrs_pkg::IDX_W'(pbmrs_pkg::NUM_THR)) begin
      thr_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign snr[0] = in_s.snr_rb0;
  assign snr[1] = in_s.snr_rb1;
  assign snr[2] = in_s.snr_rb2;
  assign snr[3] = in_s.snr_rb3;

  // Advance stage 1 whenever the output register is free or being drained
  assign out_adv   = !out_valid_q || out_m.ready;
  assign in_s.ready = !s1_valid_q || out_adv;
  assign in_acc    = in_s.valid && in_s.ready;

  for (genvar g = 0; g < pbmrs_pkg::NUM_BLOCKS; g++) begin : g_lane
    pbmrs_lane u_lane (
      .clk_i (clk_i),
      .en_i  (in_acc),
      .snr_i (snr[g]),
      .thr_i (thr_q),
      .res_o (lane_res[g])
    );
  end

  pbmrs_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (s1_valid_q && out_adv),
    .lane_i (lane_res),
    .dec_o  (dec)
  );

  always_comb begin
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (out_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    out_valid_d = out_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_m.valid     = out_valid_q;
  assign out_m.mod_rb0   = 2'(dec.mods[0]);
  assign out_m.mod_rb1   = 2'(dec.mods[1]);
  assign out_m.mod_rb2   = 2'(dec.mods[2]);
  assign out_m.mod_rb3   = 2'(dec.mods[3]);
  assign out_m.code_rate = 2'(dec.code);

`ifndef SYNTHESIS
  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid |-> (out_m.code_rate == 2'(pbmrs_pkg::RATE_12) ||
                     out_m.code_rate == 2'(pbmrs_pkg::RATE_23) ||
                     out_m.code_rate == 2'(pbmrs_pkg::RATE_34)))
    else $error("illegal code rate on output");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_adv) |=> out_m.valid)
    else $error("stage-1 word lost on its way to the output");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !(s1_valid_q && out_valid_q && !out_m.ready))
    else $error("word accepted while pipeline full");

  a_cfg_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i >= pbmrs_pkg::IDX_W'(pbmrs_pkg::NUM_THR)) |=>
      thr_q == $past(thr_q))
    else $error("write beyond the register list changed a threshold");
`endif

endmodule
